// ===== rtl/core/pose_jump_detector_assert.svh =====
// ---------------------------------------------------------------------------
// pose_jump_detector_assert.svh
// Assertion macros for the pose jump detector. They expect clk and arst_n
// in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef POSE_JUMP_DETECTOR_ASSERT_SVH
`define POSE_JUMP_DETECTOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PJD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PJD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pjd_pkg.sv =====
// ---------------------------------------------------------------------------
// pjd_pkg
// Shared widths, codes and controller/datapath interface types of the pose
// jump detector.
// ---------------------------------------------------------------------------
`default_nettype none

package pjd_pkg;

	localparam int COORD_W    = 24;
	localparam int DIST_W     = 25;
	localparam int SQ_W       = 2 * DIST_W;
	localparam int PROD_W     = 2 * COORD_W;
	localparam int THR_W      = 24;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	localparam int HISTORY_DEPTH_DEF = 6;
	localparam int WINDOW_SIZE_DEF   = 10;

	localparam logic [CFG_IDX_W-1:0] REG_CHECKING_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD  = 1'b1;

	localparam logic KIND_LATCH = 1'b1;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 24'd256;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_T,
		ST_SQ_START,
		ST_SQRT,
		ST_UPDATE,
		ST_READ,
		ST_DIV,
		ST_FINISH
	} pjd_state_t;

	typedef struct packed {
		logic load;
		logic diff;
		logic mul_x;
		logic mul_y;
		logic mul_t;
		logic sqrt_start;
		logic take_root;
		logic update;
		logic div_start;
		logic take_avg;
		logic out_load;
	} pjd_cmd_t;

	typedef struct packed {
		logic kind;
		logic sqrt_done;
		logic div_done;
		logic update_en;
	} pjd_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/pjd_isqrt.sv =====
// ---------------------------------------------------------------------------
// pjd_isqrt
// Iterative floor square root, one result bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module pjd_isqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [pjd_pkg::SQ_W-1:0]  radicand,
	output logic                           done,
	output logic [pjd_pkg::DIST_W-1:0]     root
);
	import pjd_pkg::*;

	localparam int CNT_W = $clog2(DIST_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SQ_W-1:0]  rad_q;
	logic [DIST_W:0]  rem_q;
	logic [DIST_W-1:0] root_q;

	logic [DIST_W+2:0] rem_sh;
	logic [DIST_W+2:0] trial;
	logic [DIST_W+2:0] rem_sub;
	logic              ge;
	logic [DIST_W:0]   rem_nx;

	always_comb begin
		rem_sh  = {rem_q, rad_q[SQ_W-1:SQ_W-2]};
		trial   = {1'b0, root_q, 2'b01};
		rem_sub = rem_sh - trial;
		ge      = (rem_sh >= trial);
		rem_nx  = ge ? rem_sub[DIST_W:0] : rem_sh[DIST_W:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIST_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			// consume two radicand bits per step
			rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
			rem_q  <= rem_nx;
			root_q <= {root_q[DIST_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ===== rtl/core/pjd_udiv.sv =====
// ---------------------------------------------------------------------------
// pjd_udiv
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module pjd_udiv #(
	parameter int NUM_W = 29,
	parameter int DEN_W = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] dividend,
	input  wire logic [DEN_W-1:0] divisor,
	output logic                  done,
	output logic [NUM_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;

	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_sub;
	logic             ge;
	logic [DEN_W-1:0] rem_nx;

	always_comb begin
		rem_sh  = {rem_q, num_q[NUM_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		ge      = (rem_sh >= {1'b0, den_q});
		rem_nx  = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			// quotient bits shift in where dividend bits shift out
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

`default_nettype wire

// ===== rtl/core/pjd_dp.sv =====
// ---------------------------------------------------------------------------
// pjd_dp
// Datapath: configuration, pose step, shared multiplier, square root,
// moving-average window, SLAM pose history and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module pjd_dp #(
	parameter int HISTORY_DEPTH = pjd_pkg::HISTORY_DEPTH_DEF,
	parameter int WINDOW_SIZE   = pjd_pkg::WINDOW_SIZE_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pjd_pkg::pjd_cmd_t                   cmd,
	output pjd_pkg::pjd_stat_t                       stat,
	input  wire logic                                cfg_we,
	input  wire logic [pjd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pjd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                kind,
	input  wire logic signed [pjd_pkg::COORD_W-1:0]  odom_x,
	input  wire logic signed [pjd_pkg::COORD_W-1:0]  odom_y,
	input  wire logic signed [pjd_pkg::COORD_W-1:0]  slam_x,
	input  wire logic signed [pjd_pkg::COORD_W-1:0]  slam_y,
	input  wire logic                                latch_value,
	output logic                                     jump_latched,
	output logic [pjd_pkg::DIST_W-1:0]               distance,
	output logic [pjd_pkg::DIST_W-1:0]               average_distance,
	output logic signed [pjd_pkg::COORD_W-1:0]       oldest_x,
	output logic signed [pjd_pkg::COORD_W-1:0]       oldest_y,
	output logic                                     oldest_valid
);
	import pjd_pkg::*;

	localparam int WIN_AW  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int WCNT_W  = $clog2(WINDOW_SIZE + 1);
	localparam int HCNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W   = DIST_W + $clog2(WINDOW_SIZE);
	localparam int HIST_W  = 2 * COORD_W;

	function automatic logic [COORD_W-1:0] abs_diff(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic signed [COORD_W:0] d;
		logic [COORD_W:0]        nd;
		d  = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		nd = -d;
		return d[COORD_W] ? nd[COORD_W-1:0] : d[COORD_W-1:0];
	endfunction

	// configuration and control state
	logic               checking_q;
	logic [THR_W-1:0]   thr_q;
	logic signed [COORD_W-1:0] prev_x_q;
	logic signed [COORD_W-1:0] prev_y_q;
	logic               flag_q;
	logic [WCNT_W-1:0]  win_fill_q;
	logic [WIN_AW-1:0]  win_head_q;
	logic [SUM_W-1:0]   sum_q;
	logic [DIST_W-1:0]  avg_q;
	logic [HCNT_W-1:0]  hist_fill_q;
	logic [HIST_AW-1:0] hist_head_q;
	logic [HIST_AW-1:0] oldest_q;

	// payload
	logic signed [COORD_W-1:0] ox_q;
	logic signed [COORD_W-1:0] oy_q;
	logic signed [COORD_W-1:0] sx_q;
	logic signed [COORD_W-1:0] sy_q;
	logic [COORD_W-1:0] dx_q;
	logic [COORD_W-1:0] dy_q;
	logic [PROD_W-1:0]  prod_q;
	logic [SQ_W-1:0]    sq_q;
	logic               hit_q;
	logic [DIST_W-1:0]  dist_q;
	logic [DIST_W-1:0]  win_old_q;
	logic [HIST_W-1:0]  hist_rd_q;

	logic [DIST_W-1:0]  win_mem [WINDOW_SIZE];
	logic [HIST_W-1:0]  hist_mem [HISTORY_DEPTH];

	logic               jump_q;
	logic [DIST_W-1:0]  dist_out_q;
	logic [DIST_W-1:0]  avg_out_q;
	logic [COORD_W-1:0] oldest_x_q;
	logic [COORD_W-1:0] oldest_y_q;
	logic               oldest_valid_q;

	logic [COORD_W-1:0] mul_a;
	logic [PROD_W-1:0]  prod;
	logic               win_full;
	logic               hist_full;
	logic [SUM_W-1:0]   sum_nx;
	logic               sqrt_done;
	logic [DIST_W-1:0]  root;
	logic               div_done;
	logic [SUM_W-1:0]   quot;

	// one multiplier shared by dx squared, dy squared and threshold squared
	always_comb begin
		if (cmd.mul_x) begin
			mul_a = dx_q;
		end else if (cmd.mul_y) begin
			mul_a = dy_q;
		end else begin
			mul_a = thr_q;
		end
		prod = mul_a * mul_a;
	end

	assign win_full  = (win_fill_q == WCNT_W'(WINDOW_SIZE));
	assign hist_full = (hist_fill_q == HCNT_W'(HISTORY_DEPTH));
	assign sum_nx    = sum_q + SUM_W'(dist_q) - (win_full ? SUM_W'(win_old_q) : '0);

	pjd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (sq_q),
		.done     (sqrt_done),
		.root     (root)
	);

	pjd_udiv #(
		.NUM_W (SUM_W),
		.DEN_W (WCNT_W)
	) u_udiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (win_fill_q),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checking_q  <= 1'b0;
			thr_q       <= THRESHOLD_RESET;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			flag_q      <= 1'b0;
			win_fill_q  <= '0;
			win_head_q  <= '0;
			sum_q       <= '0;
			avg_q       <= '0;
			hist_fill_q <= '0;
			hist_head_q <= '0;
			oldest_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CHECKING_ENABLE: checking_q <= cfg_data[0];
					REG_JUMP_THRESHOLD:  thr_q      <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load && kind == KIND_LATCH) begin
				flag_q <= latch_value;
			end
			if (cmd.diff) begin
				prev_x_q <= ox_q;
				prev_y_q <= oy_q;
			end
			if (cmd.update) begin
				flag_q     <= flag_q | hit_q;
				sum_q      <= sum_nx;
				win_head_q <= (win_head_q == WIN_AW'(WINDOW_SIZE - 1)) ? '0 :
					win_head_q + WIN_AW'(1);
				if (!win_full) begin
					win_fill_q <= win_fill_q + WCNT_W'(1);
				end
				hist_head_q <= (hist_head_q == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 :
					hist_head_q + HIST_AW'(1);
				// full history: the oldest entry is the one just overwritten
				if (hist_full) begin
					oldest_q <= (oldest_q == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 :
						oldest_q + HIST_AW'(1);
				end else begin
					hist_fill_q <= hist_fill_q + HCNT_W'(1);
				end
			end
			if (cmd.take_avg) begin
				avg_q <= quot[DIST_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ox_q <= odom_x;
			oy_q <= odom_y;
			sx_q <= slam_x;
			sy_q <= slam_y;
			if (kind == KIND_LATCH) begin
				dist_q <= '0;
			end
		end
		if (cmd.diff) begin
			dx_q      <= abs_diff(ox_q, prev_x_q);
			dy_q      <= abs_diff(oy_q, prev_y_q);
			win_old_q <= win_mem[win_head_q];
		end
		if (cmd.mul_x) begin
			prod_q <= prod;
		end
		if (cmd.mul_y) begin
			sq_q   <= SQ_W'(prod_q);
			prod_q <= prod;
		end
		if (cmd.mul_t) begin
			sq_q   <= sq_q + SQ_W'(prod_q);
			prod_q <= prod;
		end
		if (cmd.sqrt_start) begin
			hit_q <= (sq_q > SQ_W'(prod_q));
		end
		if (cmd.take_root) begin
			dist_q <= root;
		end
		if (cmd.update) begin
			win_mem[win_head_q]   <= dist_q;
			hist_mem[hist_head_q] <= {sx_q, sy_q};
		end
		if (cmd.div_start) begin
			hist_rd_q <= hist_mem[oldest_q];
		end
		if (cmd.out_load) begin
			jump_q         <= flag_q;
			dist_out_q     <= dist_q;
			avg_out_q      <= avg_q;
			oldest_valid_q <= (hist_fill_q != '0);
			if (hist_fill_q != '0) begin
				oldest_x_q <= hist_rd_q[HIST_W-1:COORD_W];
				oldest_y_q <= hist_rd_q[COORD_W-1:0];
			end else begin
				oldest_x_q <= '0;
				oldest_y_q <= '0;
			end
		end
	end

	always_comb begin
		stat.kind      = kind;
		stat.sqrt_done = sqrt_done;
		stat.div_done  = div_done;
		stat.update_en = checking_q && !flag_q;
	end

	assign jump_latched     = jump_q;
	assign distance         = dist_out_q;
	assign average_distance = avg_out_q;
	assign oldest_x         = $signed(oldest_x_q);
	assign oldest_y         = $signed(oldest_y_q);
	assign oldest_valid     = oldest_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/pjd_ctrl.sv =====
// ---------------------------------------------------------------------------
// pjd_ctrl
// Sequencer of the pose jump detector: steps one request through the
// datapath and holds the result until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module pjd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output pjd_pkg::pjd_cmd_t        cmd,
	input  wire pjd_pkg::pjd_stat_t  stat
);
	import pjd_pkg::*;

	pjd_state_t state_q;
	pjd_state_t state_nx;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = (stat.kind == KIND_LATCH) ? ST_FINISH : ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_nx = ST_MUL_X;
			end
			ST_MUL_X: begin
				cmd.mul_x = 1'b1;
				state_nx  = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				cmd.mul_y = 1'b1;
				state_nx  = ST_MUL_T;
			end
			ST_MUL_T: begin
				cmd.mul_t = 1'b1;
				state_nx  = ST_SQ_START;
			end
			ST_SQ_START: begin
				cmd.sqrt_start = 1'b1;
				state_nx       = ST_SQRT;
			end
			ST_SQRT: begin
				if (stat.sqrt_done) begin
					cmd.take_root = 1'b1;
					state_nx      = stat.update_en ? ST_UPDATE : ST_FINISH;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_nx   = ST_READ;
			end
			ST_READ: begin
				cmd.div_start = 1'b1;
				state_nx      = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) begin
					cmd.take_avg = 1'b1;
					state_nx     = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/pose_jump_detector.sv =====
// ---------------------------------------------------------------------------
// pose_jump_detector
// Odometry pose jump detector with distance moving average and SLAM pose
// history.
// ---------------------------------------------------------------------------
// One request is processed at a time. With the output register free, a latch
// request goes from acceptance straight to the finish state, which loads its
// result into the output register. A pose request runs a difference step,
// three passes through one shared 24x24 multiplier and a bit-serial square
// root; with a window update, the update and a bit-serial divide of the
// window sum by its fill count follow. A finished result sits in an output
// register, so the next request is accepted while it waits to be taken.
// Configuration writes are taken at any cycle and must only be issued while
// idle.
// ---------------------------------------------------------------------------
`default_nettype none

module pose_jump_detector #(
	parameter int HISTORY_DEPTH = pjd_pkg::HISTORY_DEPTH_DEF,
	parameter int WINDOW_SIZE   = pjd_pkg::WINDOW_SIZE_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [pjd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pjd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                kind,
	input  wire logic signed [pjd_pkg::COORD_W-1:0]  odom_x,
	input  wire logic signed [pjd_pkg::COORD_W-1:0]  odom_y,
	input  wire logic signed [pjd_pkg::COORD_W-1:0]  slam_x,
	input  wire logic signed [pjd_pkg::COORD_W-1:0]  slam_y,
	input  wire logic                                latch_value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     jump_latched,
	output logic [pjd_pkg::DIST_W-1:0]               distance,
	output logic [pjd_pkg::DIST_W-1:0]               average_distance,
	output logic signed [pjd_pkg::COORD_W-1:0]       oldest_x,
	output logic signed [pjd_pkg::COORD_W-1:0]       oldest_y,
	output logic                                     oldest_valid
);
	import pjd_pkg::*;

`include "pose_jump_detector_assert.svh"

	pjd_cmd_t  cmd;
	pjd_stat_t stat;

	assign cfg_ready = 1'b1;

	pjd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	pjd_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.WINDOW_SIZE   (WINDOW_SIZE)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.kind             (kind),
		.odom_x           (odom_x),
		.odom_y           (odom_y),
		.slam_x           (slam_x),
		.slam_y           (slam_y),
		.latch_value      (latch_value),
		.jump_latched     (jump_latched),
		.distance         (distance),
		.average_distance (average_distance),
		.oldest_x         (oldest_x),
		.oldest_y         (oldest_y),
		.oldest_valid     (oldest_valid)
	);

	`PJD_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "request accepted while busy")
	`PJD_ASSERT_NOW(a_update_gated, cmd.update, stat.update_en, "window update while disabled")
	`PJD_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "result overwritten")

endmodule

`default_nettype wire
